FILE: src/lcabl_pkg.sv
// Package for the binary-lifting LCA engine: sizes, request/result structs,
// memory port structs, sequencer states and address helpers.
// No dependencies.
package lcabl_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 10;

  localparam int NODE_W    = 10;
  localparam int DEPTH_W   = 10;
  localparam int PATH_W    = 11;
  localparam int DEPTH_MAX = (2 ** DEPTH_W) - 1;

  localparam int LVL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int DEP_AW    = $clog2(MAX_NODES);
  localparam int ANC_DEPTH = MAX_NODES * LIFT_LEVELS;
  localparam int ANC_AW    = $clog2(ANC_DEPTH);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [PATH_W-1:0]  path_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [ANC_AW-1:0]  anc_addr_t;
  typedef logic [DEP_AW-1:0]  dep_addr_t;

  localparam lvl_t LAST_LVL = LVL_W'(LIFT_LEVELS - 1);

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } lcabl_op_e;

  typedef struct packed {
    lcabl_op_e op;
    node_t     node_a;
    node_t     node_b;
  } lcabl_req_t;

  typedef struct packed {
    node_t common_ancestor;
    path_t path_length;
  } lcabl_res_t;

  typedef struct packed {
    logic      anc_we;
    anc_addr_t anc_waddr;
    node_t     anc_wdata;
    anc_addr_t anc_raddr_a;
    anc_addr_t anc_raddr_b;
    logic      dep_we;
    dep_addr_t dep_waddr;
    depth_t    dep_wdata;
    dep_addr_t dep_raddr;
  } lcabl_mem_req_t;

  typedef struct packed {
    node_t  anc_rdata_a;
    node_t  anc_rdata_b;
    depth_t dep_rdata;
  } lcabl_mem_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_DEP,
    S_ADD_WR,
    S_ADD_RD,
    S_Q_DEPA,
    S_Q_DEPB,
    S_Q_SWAP,
    S_Q_UP_RA,
    S_Q_UP_RD,
    S_Q_UP_CMP,
    S_Q_EQ,
    S_Q_LO_RA,
    S_Q_LO_CMP,
    S_Q_FIN,
    S_Q_DL
  } lcabl_state_e;

  function automatic anc_addr_t anc_addr(node_t n, lvl_t l);
    anc_addr_t a;
    a = ANC_AW'(n) * ANC_AW'(LIFT_LEVELS) + ANC_AW'(l);
    return a;
  endfunction

  function automatic dep_addr_t dep_addr(node_t n);
    return DEP_AW'(n);
  endfunction

  function automatic logic node_ok(node_t n);
    return (32'(n) < 32'(MAX_NODES));
  endfunction

endpackage

FILE: src/lcabl_mem.sv
// Ancestor table and depth table memories, one write port each,
// registered read data. Depends on lcabl_pkg.
module lcabl_mem (
  input  logic                     clk_i,
  input  lcabl_pkg::lcabl_mem_req_t mem_req_i,
  output lcabl_pkg::lcabl_mem_rsp_t mem_rsp_o
);
  import lcabl_pkg::*;

  node_t  anc_mem [ANC_DEPTH];
  depth_t dep_mem [MAX_NODES];

  node_t  anc_rdata_a_q;
  node_t  anc_rdata_b_q;
  depth_t dep_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.anc_we) begin
      anc_mem[mem_req_i.anc_waddr] <= mem_req_i.anc_wdata;
    end
    anc_rdata_a_q <= anc_mem[mem_req_i.anc_raddr_a];
    anc_rdata_b_q <= anc_mem[mem_req_i.anc_raddr_b];
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.dep_we) begin
      dep_mem[mem_req_i.dep_waddr] <= mem_req_i.dep_wdata;
    end
    dep_rdata_q <= dep_mem[mem_req_i.dep_raddr];
  end

  assign mem_rsp_o.anc_rdata_a = anc_rdata_a_q;
  assign mem_rsp_o.anc_rdata_b = anc_rdata_b_q;
  assign mem_rsp_o.dep_rdata   = dep_rdata_q;

endmodule

FILE: src/lcabl_ctrl.sv
// Sequencer and datapath of the LCA engine: add fill, lift, lockstep
// climb and distance. Depends on lcabl_pkg; drives lcabl_mem.
module lcabl_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  lcabl_pkg::lcabl_req_t     req_i,
  output logic                      busy_o,
  output logic                      valid_o,
  output lcabl_pkg::lcabl_res_t     res_o,
  output lcabl_pkg::lcabl_mem_req_t mem_req_o,
  input  lcabl_pkg::lcabl_mem_rsp_t mem_rsp_i
);
  import lcabl_pkg::*;

  lcabl_state_e state_q, state_d;
  lvl_t         lvl_q, lvl_d;
  node_t        u_q, u_d, v_q, v_d, node_q, node_d, val_q, val_d;
  node_t        up_q, up_d, l_q, l_d;
  depth_t       du_q, du_d, dv_q, dv_d, da_q, da_d, db_q, db_d;
  lcabl_res_t   res_q, res_d;
  logic         valid_q, valid_d;

  logic         accept;
  depth_t       dl_sel;
  path_t        depth_sum;
  path_t        depth_twice;
  path_t        path_len;
  depth_t       dep_inc;

  assign accept = start_i && (state_q == S_IDLE);

  // Distance unit: da + db - 2*dl, floored at zero.
  assign dl_sel      = (state_q == S_Q_EQ) ? du_q : mem_rsp_i.dep_rdata;
  assign depth_sum   = PATH_W'(da_q) + PATH_W'(db_q);
  assign depth_twice = {dl_sel, 1'b0};
  assign path_len    = (depth_sum < depth_twice) ? '0 : (depth_sum - depth_twice);

  assign dep_inc = (mem_rsp_i.dep_rdata == depth_t'(DEPTH_MAX)) ?
                   mem_rsp_i.dep_rdata : (mem_rsp_i.dep_rdata + 1'b1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.op == OP_ADD) begin
            if (node_ok(req_i.node_a) && node_ok(req_i.node_b)) begin
              state_d = S_ADD_DEP;
            end
          end else if (node_ok(req_i.node_a) && node_ok(req_i.node_b)) begin
            state_d = S_Q_DEPA;
          end
        end
      end
      S_ADD_DEP:  state_d = S_ADD_WR;
      S_ADD_WR:   state_d = (lvl_q == LAST_LVL) ? S_IDLE : S_ADD_RD;
      S_ADD_RD:   state_d = S_ADD_WR;
      S_Q_DEPA:   state_d = S_Q_DEPB;
      S_Q_DEPB:   state_d = S_Q_SWAP;
      S_Q_SWAP:   state_d = S_Q_UP_RA;
      S_Q_UP_RA:  state_d = S_Q_UP_RD;
      S_Q_UP_RD:  state_d = S_Q_UP_CMP;
      S_Q_UP_CMP: state_d = (lvl_q == '0) ? S_Q_EQ : S_Q_UP_RD;
      S_Q_EQ:     state_d = (u_q == v_q) ? S_IDLE : S_Q_LO_RA;
      S_Q_LO_RA:  state_d = S_Q_LO_CMP;
      S_Q_LO_CMP: state_d = (lvl_q == '0) ? S_Q_FIN : S_Q_LO_CMP;
      S_Q_FIN:    state_d = S_Q_DL;
      S_Q_DL:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    lvl_d   = lvl_q;
    u_d     = u_q;
    v_d     = v_q;
    node_d  = node_q;
    val_d   = val_q;
    up_d    = up_q;
    l_d     = l_q;
    du_d    = du_q;
    dv_d    = dv_q;
    da_d    = da_q;
    db_d    = db_q;
    res_d   = res_q;
    valid_d = 1'b0;

    mem_req_o.anc_we      = 1'b0;
    mem_req_o.anc_waddr   = anc_addr(node_q, lvl_q);
    mem_req_o.anc_wdata   = val_q;
    mem_req_o.anc_raddr_a = anc_addr(u_q, lvl_q);
    mem_req_o.anc_raddr_b = anc_addr(v_q, lvl_q);
    mem_req_o.dep_we      = 1'b0;
    mem_req_o.dep_waddr   = dep_addr(node_q);
    mem_req_o.dep_wdata   = dep_inc;
    mem_req_o.dep_raddr   = dep_addr(u_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          u_d    = req_i.node_a;
          v_d    = req_i.node_b;
          node_d = req_i.node_a;
          val_d  = req_i.node_b;
          lvl_d  = '0;
          if ((req_i.op == OP_QUERY) &&
              !(node_ok(req_i.node_a) && node_ok(req_i.node_b))) begin
            res_d   = '0;
            valid_d = 1'b1;
          end
        end
      end
      S_ADD_DEP: begin
        mem_req_o.dep_raddr = dep_addr(val_q);
      end
      S_ADD_WR: begin
        // Level zero is the parent itself; higher levels come from the read.
        mem_req_o.anc_we    = 1'b1;
        mem_req_o.anc_wdata = (lvl_q == '0) ? val_q : mem_rsp_i.anc_rdata_a;
        val_d               = mem_req_o.anc_wdata;
        if (lvl_q == '0) begin
          mem_req_o.dep_we    = 1'b1;
          mem_req_o.dep_wdata = (node_q == val_q) ? '0 : dep_inc;
        end
      end
      S_ADD_RD: begin
        mem_req_o.anc_raddr_a = anc_addr(val_q, lvl_q);
        lvl_d                 = lvl_q + 1'b1;
      end
      S_Q_DEPA: begin
        mem_req_o.dep_raddr = dep_addr(u_q);
      end
      S_Q_DEPB: begin
        mem_req_o.dep_raddr = dep_addr(v_q);
        da_d                = mem_rsp_i.dep_rdata;
      end
      S_Q_SWAP: begin
        db_d  = mem_rsp_i.dep_rdata;
        lvl_d = LAST_LVL;
        if (da_q < mem_rsp_i.dep_rdata) begin
          u_d  = v_q;
          v_d  = u_q;
          du_d = mem_rsp_i.dep_rdata;
          dv_d = da_q;
        end else begin
          du_d = da_q;
          dv_d = mem_rsp_i.dep_rdata;
        end
      end
      S_Q_UP_RA: begin
        mem_req_o.anc_raddr_a = anc_addr(u_q, lvl_q);
      end
      S_Q_UP_RD: begin
        up_d                = mem_rsp_i.anc_rdata_a;
        mem_req_o.dep_raddr = dep_addr(mem_rsp_i.anc_rdata_a);
      end
      S_Q_UP_CMP: begin
        // Take the jump if it does not pass the shallower node's depth.
        if (mem_rsp_i.dep_rdata >= dv_q) begin
          u_d  = up_q;
          du_d = mem_rsp_i.dep_rdata;
        end
        if (lvl_q != '0) begin
          lvl_d                 = lvl_q - 1'b1;
          mem_req_o.anc_raddr_a = anc_addr(u_d, lvl_d);
        end
      end
      S_Q_EQ: begin
        if (u_q == v_q) begin
          res_d.common_ancestor = u_q;
          res_d.path_length     = path_len;
          valid_d               = 1'b1;
        end else begin
          lvl_d = LAST_LVL;
        end
      end
      S_Q_LO_RA: begin
        mem_req_o.anc_raddr_a = anc_addr(u_q, lvl_q);
        mem_req_o.anc_raddr_b = anc_addr(v_q, lvl_q);
      end
      S_Q_LO_CMP: begin
        // Climb both nodes together while their ancestors differ.
        if (mem_rsp_i.anc_rdata_a != mem_rsp_i.anc_rdata_b) begin
          u_d = mem_rsp_i.anc_rdata_a;
          v_d = mem_rsp_i.anc_rdata_b;
        end
        if (lvl_q != '0) begin
          lvl_d                 = lvl_q - 1'b1;
          mem_req_o.anc_raddr_a = anc_addr(u_d, lvl_d);
          mem_req_o.anc_raddr_b = anc_addr(v_d, lvl_d);
        end else begin
          mem_req_o.anc_raddr_a = anc_addr(u_d, '0);
        end
      end
      S_Q_FIN: begin
        l_d                 = mem_rsp_i.anc_rdata_a;
        mem_req_o.dep_raddr = dep_addr(mem_rsp_i.anc_rdata_a);
      end
      S_Q_DL: begin
        res_d.common_ancestor = l_q;
        res_d.path_length     = path_len;
        valid_d               = 1'b1;
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    u_q    <= u_d;
    v_q    <= v_d;
    node_q <= node_d;
    val_q  <= val_d;
    up_q   <= up_d;
    l_q    <= l_d;
    du_q   <= du_d;
    dv_q   <= dv_d;
    da_q   <= da_d;
    db_q   <= db_d;
    res_q  <= res_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTHESIS
  a_valid_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (state_q == S_IDLE))
    else $error("result strobe outside idle state");

  a_query_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.op == OP_QUERY)) |=> (busy_o || valid_q))
    else $error("query neither started nor answered");

  a_add_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.op == OP_ADD)) |=> !valid_q)
    else $error("add request produced a result");

  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && (state_q != S_ADD_DEP)) |-> (lvl_q <= LAST_LVL))
    else $error("lifting level out of range");
`endif

endmodule

FILE: src/lca_binary_lifting_engine_top.sv
// Top level of the binary-lifting LCA engine.
// Depends on lcabl_pkg, lcabl_ctrl and lcabl_mem.
//
// Load the tree parent first with add requests (op = add, node_a = node,
// node_b = parent, the node itself for a root), then issue query requests
// (op = query) for the lowest common ancestor and edge distance of two
// nodes. A request is taken on a rising edge with start_i high and busy_o
// low; busy_o then stays high until the request is finished. An add gives
// no result: it reads the parent depth, then writes each lifting level in
// turn, with a read before each level above the first, all through the
// single ancestor table write port. A query reads both depths and orders
// the two nodes, issues the first ancestor read, lifts the deeper node
// level by level (ancestor read, then depth read), checks for equal nodes,
// issues the first pair of lockstep reads, climbs both nodes in lockstep
// level by level on the two ancestor read ports, and reads the parent and
// its depth. A query that finds equal nodes after lifting ends early.
// The result appears on res_o for exactly one cycle with valid_o high, in
// the first cycle with busy_o low again; there is no back-pressure, so the
// receiver must capture it then. A new request may be taken during that
// cycle. Query nodes that were never added give undefined results. The
// tables have no reset and need no clearing pass.
module lca_binary_lifting_engine_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  lcabl_pkg::lcabl_req_t req_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output lcabl_pkg::lcabl_res_t res_o
);
  import lcabl_pkg::*;

  lcabl_mem_req_t mem_req;
  lcabl_mem_rsp_t mem_rsp;

  // Sequencer: owns the walk over lifting levels and the result register.
  lcabl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .req_i     (req_i),
    .busy_o    (busy_o),
    .valid_o   (valid_o),
    .res_o     (res_o),
    .mem_req_o (mem_req),
    .mem_rsp_i (mem_rsp)
  );

  // Ancestor and depth tables, read data registered.
  lcabl_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .mem_rsp_o (mem_rsp)
  );

endmodule

FILE: dv/lcabl_checker.sv
// Scoreboard for the binary-lifting LCA engine: mirrors the ancestor and depth
// tables, predicts every query result and compares it on the result strobe.
// Depends on lcabl_pkg.
module lcabl_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  lcabl_pkg::lcabl_req_t req_i,
  input  logic                  valid_i,
  input  lcabl_pkg::lcabl_res_t res_i,
  output int                    mismatch_cnt_o,
  output int                    pending_o
);
  import lcabl_pkg::*;

  localparam int PATH_LIMIT = 2046;
  localparam int REPORT_MAX = 10;

  node_t      lift_tbl  [MAX_NODES][LIFT_LEVELS];
  depth_t     depth_tbl [MAX_NODES];
  lcabl_res_t lca_expect_q [$];
  lcabl_res_t want;
  int         mismatches;

  // Both tables read as zero until written.
  initial begin
    for (int n = 0; n < MAX_NODES; n++) begin
      depth_tbl[n] = '0;
      for (int l = 0; l < LIFT_LEVELS; l++) lift_tbl[n][l] = '0;
    end
    mismatches     = 0;
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  task automatic flag_mismatch(input string what, input int exp_val, input int got_val);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    end
  endtask

  // Every 10-bit node lies below MAX_NODES, so no range guard is needed.
  function automatic void record_add(node_t node, node_t parent);
    int d;
    if (node == parent) begin
      d = 0;
    end else begin
      d = int'(depth_tbl[parent]) + 1;
      if (d > DEPTH_MAX) d = DEPTH_MAX;
    end
    depth_tbl[node]   = depth_t'(d);
    lift_tbl[node][0] = parent;
    for (int j = 1; j < LIFT_LEVELS; j++) begin
      lift_tbl[node][j] = lift_tbl[lift_tbl[node][j-1]][j-1];
    end
  endfunction

  function automatic lcabl_res_t predict_lca(node_t a, node_t b);
    node_t      u;
    node_t      v;
    node_t      t;
    node_t      up;
    node_t      lca;
    int         path_len;
    lcabl_res_t r;
    u = a;
    v = b;
    if (depth_tbl[u] < depth_tbl[v]) begin
      t = u;
      u = v;
      v = t;
    end
    // Lift the deeper node to the depth of the shallower one.
    for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
      up = lift_tbl[u][i];
      if (depth_tbl[up] >= depth_tbl[v]) u = up;
    end
    if (u == v) begin
      lca = u;
    end else begin
      for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
        if (lift_tbl[u][i] != lift_tbl[v][i]) begin
          u = lift_tbl[u][i];
          v = lift_tbl[v][i];
        end
      end
      lca = lift_tbl[u][0];
    end
    path_len = int'(depth_tbl[a]) + int'(depth_tbl[b]) - 2 * int'(depth_tbl[lca]);
    if (path_len < 0) path_len = 0;
    if (path_len > PATH_LIMIT) path_len = PATH_LIMIT;
    r.common_ancestor = lca;
    r.path_length     = path_t'(path_len);
    return r;
  endfunction

  // Compare the strobed result first, then take in the request of this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i) begin
        if (lca_expect_q.size() == 0) begin
          flag_mismatch("result with none pending", -1, int'(res_i.common_ancestor));
        end else begin
          want = lca_expect_q.pop_front();
          if (res_i.common_ancestor !== want.common_ancestor) begin
            flag_mismatch("common_ancestor", int'(want.common_ancestor),
                          int'(res_i.common_ancestor));
          end
          if (res_i.path_length !== want.path_length) begin
            flag_mismatch("path_length", int'(want.path_length), int'(res_i.path_length));
          end
        end
      end
      if (start_i && !busy_i) begin
        if (req_i.op == OP_QUERY) begin
          lca_expect_q = {lca_expect_q, predict_lca(req_i.node_a, req_i.node_b)};
        end else begin
          record_add(req_i.node_a, req_i.node_b);
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= lca_expect_q.size();
  end

endmodule

FILE: dv/tb.sv
// Testbench top for the binary-lifting LCA engine: builds trees parent first,
// issues add and query requests, and gives the verdict.
// Depends on lcabl_pkg, lcabl_checker and lca_binary_lifting_engine_top.
module tb;
  import lcabl_pkg::*;

  // Length of the deep chain built at the end of the run.
  localparam int CHAIN_LEN = 256;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  lcabl_req_t req_i;
  logic       busy_o;
  logic       valid_o;
  lcabl_res_t res_o;
  int         mismatch_cnt;
  int         pending_cnt;

  // Percentage of cycles in which the sender holds start low.
  int         idle_pct;
  // Nodes added so far, in order of first addition; recent ones sit at the back.
  node_t      tree_nodes_q [$];
  bit         on_tree [MAX_NODES];
  int         chain_order [MAX_NODES];

  lca_binary_lifting_engine_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  lcabl_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_i          (req_i),
    .valid_i        (valid_o),
    .res_i          (res_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Issue one request. Called at a falling edge; returns at the falling edge
  // after the request was taken. Idle cycles come first, so start stays high
  // across back-to-back requests without being lowered in between.
  task automatic issue(input lcabl_op_e op, input node_t a, input node_t b);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= '{op: op, node_a: a, node_b: b};
    // Hold the request until an edge finds busy low.
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    if (op == OP_ADD && !on_tree[a]) begin
      on_tree[a]   = 1'b1;
      tree_nodes_q = {tree_nodes_q, a};
    end
  endtask

  // Drop start and hold off until every pending query result has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  function automatic node_t pick_node();
    return tree_nodes_q[$urandom_range(0, tree_nodes_q.size() - 1)];
  endfunction

  // A node never added so far; once the tree is full, any added node.
  function automatic node_t fresh_node();
    node_t n;
    if (tree_nodes_q.size() >= MAX_NODES) return pick_node();
    do n = node_t'($urandom_range(0, MAX_NODES - 1)); while (on_tree[n]);
    return n;
  endfunction

  // Grow the random forest and query it. Parents lean toward recently added
  // nodes so the tree gets deep enough to use the upper lifting levels.
  // Every query names nodes already on the tree, never an unwritten entry.
  task automatic random_burst(input int count);
    node_t a;
    node_t b;
    int    span;
    for (int k = 0; k < count; k++) begin
      if (tree_nodes_q.size() == 0 || $urandom_range(0, 99) < 3) begin
        // Start a new root.
        a = fresh_node();
        issue(OP_ADD, a, a);
      end else if ($urandom_range(0, 99) < 50) begin
        if ($urandom_range(0, 1) == 0) begin
          span = (tree_nodes_q.size() < 8) ? tree_nodes_q.size() : 8;
          b = tree_nodes_q[tree_nodes_q.size() - 1 - $urandom_range(0, span - 1)];
        end else begin
          b = pick_node();
        end
        // Mostly new nodes; now and then re-add one that is already there.
        a = ($urandom_range(0, 99) < 8) ? pick_node() : fresh_node();
        issue(OP_ADD, a, b);
      end else begin
        a = pick_node();
        case ($urandom_range(0, 9))
          0:       b = a;
          1:       b = tree_nodes_q[0];
          2:       b = tree_nodes_q[tree_nodes_q.size() - 1];
          default: b = pick_node();
        endcase
        issue(OP_QUERY, a, b);
      end
    end
  endtask

  initial begin
    int j;
    int t;
    node_t head;
    node_t tail;

    rst_ni   = 1'b0;
    start_i  = 1'b0;
    req_i    = '0;
    idle_pct = 14;
    foreach (on_tree[n]) on_tree[n] = 1'b0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed tree: root at the lowest node, the highest node and
    // alternating bit patterns below it.
    issue(OP_ADD,   10'd0,    10'd0);
    issue(OP_ADD,   10'd1023, 10'd0);
    issue(OP_ADD,   10'd5,    10'd1023);
    issue(OP_ADD,   10'd6,    10'd1023);
    issue(OP_ADD,   10'd512,  10'd5);
    issue(OP_ADD,   10'd341,  10'd6);
    issue(OP_ADD,   10'd682,  10'd341);
    // Same node, root against itself, node against its ancestor both ways.
    issue(OP_QUERY, 10'd0,    10'd0);
    issue(OP_QUERY, 10'd512,  10'd512);
    issue(OP_QUERY, 10'd512,  10'd0);
    issue(OP_QUERY, 10'd0,    10'd512);
    // Siblings, cousins of unequal depth, and the highest node as ancestor.
    issue(OP_QUERY, 10'd5,    10'd6);
    issue(OP_QUERY, 10'd512,  10'd682);
    issue(OP_QUERY, 10'd1023, 10'd682);
    // Re-add a leaf under a different parent.
    issue(OP_ADD,   10'd512,  10'd6);
    issue(OP_QUERY, 10'd512,  10'd341);
    issue(OP_QUERY, 10'd682,  10'd512);
    // A second root: query across two separate trees.
    issue(OP_ADD,   10'd777,  10'd777);
    issue(OP_QUERY, 10'd777,  10'd0);
    issue(OP_QUERY, 10'd682,  10'd777);
    // Pause the sender until every result is back.
    drain_results();

    // Random part under three idling settings.
    random_burst(40);
    drain_results();
    idle_pct = 79;
    random_burst(40);
    drain_results();
    idle_pct = 0;
    random_burst(40);

    // Deep chain over shuffled nodes, parent first, so that the upper
    // lifting levels carry real ancestors.
    for (int n = 0; n < MAX_NODES; n++) chain_order[n] = n;
    for (int n = MAX_NODES - 1; n > 0; n--) begin
      j              = $urandom_range(0, n);
      t              = chain_order[n];
      chain_order[n] = chain_order[j];
      chain_order[j] = t;
    end
    head = node_t'(chain_order[0]);
    tail = node_t'(chain_order[CHAIN_LEN - 1]);
    issue(OP_ADD, head, head);
    for (int n = 1; n < CHAIN_LEN; n++) begin
      issue(OP_ADD, node_t'(chain_order[n]), node_t'(chain_order[n - 1]));
      if (n % 32 == 0) begin
        issue(OP_QUERY, node_t'(chain_order[$urandom_range(0, n)]),
              node_t'(chain_order[$urandom_range(0, n)]));
      end
    end
    // Deepest node against the root, both ways, and against the middle.
    issue(OP_QUERY, tail, head);
    issue(OP_QUERY, head, tail);
    issue(OP_QUERY, tail, node_t'(chain_order[CHAIN_LEN / 2]));

    // Hang the root under the deepest node: the tables no longer agree
    // with the depths, so queries walk inconsistent entries.
    issue(OP_ADD, head, tail);
    issue(OP_QUERY, head, tail);
    issue(OP_QUERY, tail, head);
    issue(OP_ADD, node_t'(chain_order[3]), head);
    issue(OP_QUERY, node_t'(chain_order[3]), node_t'(chain_order[1]));
    for (int n = 0; n < 8; n++) begin
      issue(OP_QUERY, node_t'(chain_order[$urandom_range(0, CHAIN_LEN - 1)]),
            node_t'(chain_order[$urandom_range(0, 7)]));
    end

    // Let the last results arrive, then give a trailing add time to finish.
    drain_results();
    repeat (3 * LIFT_LEVELS + 10) @(negedge clk_i);

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: lca_binary_lifting_engine_top.f
src/lcabl_pkg.sv
src/lcabl_mem.sv
src/lcabl_ctrl.sv
src/lca_binary_lifting_engine_top.sv
dv/lcabl_checker.sv
dv/tb.sv
